/* design/bc3d_pkg.sv */
package bc3d_pkg;

	// Depth of the block queue between the front and back parts.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Reciprocals for truncating division by 7, 5 and 3 of sums below 2048.
	// Each is exact over the whole range that the palette sums can reach.
	localparam int RECIP_SHIFT = 16;
	localparam logic [15:0] RECIP7 = 16'd9363;
	localparam logic [15:0] RECIP5 = 16'd13108;
	localparam logic [15:0] RECIP3 = 16'd21846;

	typedef logic [7:0] chan_t;
	typedef logic [23:0] color_t;

	// One decoded block: both palettes plus the raw texel indices.
	typedef struct packed {
		logic [7:0][7:0] alpha;
		logic [3:0][23:0] color;
		logic [47:0] abits;
		logic [31:0] cbits;
	} entry_t;

	// Queue status seen by the producer and the consumer.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Undo the swap of each adjacent byte pair.
	function automatic logic [63:0] unswap_pairs(input logic [63:0] x);
		logic [63:0] y;
		y = '0;
		for (int m = 0; m < 4; m++) begin
			y[16*m +: 8] = x[16*m + 8 +: 8];
			y[16*m + 8 +: 8] = x[16*m +: 8];
		end
		return y;
	endfunction

	// Widen a 565 color to 8 bits per channel, R in the low byte.
	function automatic color_t widen565(input logic [15:0] v);
		logic [4:0] r;
		logic [5:0] g;
		logic [4:0] b;
		r = v[15:11];
		g = v[10:5];
		b = v[4:0];
		return {b, b[4:2], g, g[5:4], r, r[4:2]};
	endfunction

	// Truncating division by a small constant through its reciprocal.
	function automatic chan_t recip_mul(input logic [10:0] x, input logic [15:0] recip);
		logic [26:0] p;
		p = 27'(x) * 27'(recip);
		return p[RECIP_SHIFT +: 8];
	endfunction

endpackage

/* design/bc3d_front.sv */
module bc3d_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [63:0] stored_low,
	input logic [63:0] stored_high,
	input bc3d_pkg::qstat_t qstat,
	output logic push,
	output bc3d_pkg::entry_t entry
);

	// Stage 1 registers: endpoints, palette sums and indices.
	logic s1_v_q;
	logic [7:0] a0_s1;
	logic [7:0] a1_s1;
	logic gt_s1;
	logic [5:0][10:0] asum_s1;
	bc3d_pkg::color_t col0_s1;
	bc3d_pkg::color_t col1_s1;
	logic [1:0][2:0][9:0] csum_s1;
	logic [47:0] abits_s1;
	logic [31:0] cbits_s1;

	// Stage 2 register: the finished block entry.
	logic s2_v_q;
	bc3d_pkg::entry_t entry_s2;

	logic [63:0] lo;
	logic [63:0] hi;
	logic [7:0] a0;
	logic [7:0] a1;
	logic gt;
	logic [5:0][10:0] asum;
	bc3d_pkg::color_t col0;
	bc3d_pkg::color_t col1;
	logic [1:0][2:0][9:0] csum;
	bc3d_pkg::entry_t entry_nx;
	logic accept;
	logic s2_adv;
	logic [15:0] arecip;

	// Flow control across the two stages.
	assign push = s2_v_q && !qstat.full;
	assign s2_adv = !s2_v_q || push;
	assign in_stall = s1_v_q && !s2_adv;
	assign accept = in_valid && !in_stall;
	assign entry = entry_s2;

	// Restore byte order, widen endpoints and form the weighted sums.
	always_comb begin
		lo = bc3d_pkg::unswap_pairs(stored_low);
		hi = bc3d_pkg::unswap_pairs(stored_high);
		a0 = lo[7:0];
		a1 = lo[15:8];
		gt = a0 > a1;
		for (int k = 0; k < 6; k++) begin
			if (gt) begin
				asum[k] = 11'(11'(a0) * 11'(6 - k)) + 11'(11'(a1) * 11'(k + 1));
			end else if (k < 4) begin
				asum[k] = 11'(11'(a0) * 11'(4 - k)) + 11'(11'(a1) * 11'(k + 1));
			end else begin
				asum[k] = '0;
			end
		end
		col0 = bc3d_pkg::widen565(hi[15:0]);
		col1 = bc3d_pkg::widen565(hi[31:16]);
		for (int ch = 0; ch < 3; ch++) begin
			csum[0][ch] = 10'({col0[8*ch +: 8], 1'b0}) + 10'(col1[8*ch +: 8]);
			csum[1][ch] = 10'(col0[8*ch +: 8]) + 10'({col1[8*ch +: 8], 1'b0});
		end
	end

	// Divide the sums and assemble both palettes.
	always_comb begin
		arecip = gt_s1 ? bc3d_pkg::RECIP7 : bc3d_pkg::RECIP5;
		entry_nx.alpha[0] = a0_s1;
		entry_nx.alpha[1] = a1_s1;
		for (int k = 0; k < 6; k++) begin
			if (gt_s1 || k < 4) begin
				entry_nx.alpha[k + 2] = bc3d_pkg::recip_mul(asum_s1[k], arecip);
			end else if (k == 4) begin
				entry_nx.alpha[k + 2] = 8'd0;
			end else begin
				entry_nx.alpha[k + 2] = 8'd255;
			end
		end
		entry_nx.color[0] = col0_s1;
		entry_nx.color[1] = col1_s1;
		for (int ch = 0; ch < 3; ch++) begin
			entry_nx.color[2][8*ch +: 8] =
				bc3d_pkg::recip_mul(11'(csum_s1[0][ch]), bc3d_pkg::RECIP3);
			entry_nx.color[3][8*ch +: 8] =
				bc3d_pkg::recip_mul(11'(csum_s1[1][ch]), bc3d_pkg::RECIP3);
		end
		entry_nx.abits = abits_s1;
		entry_nx.cbits = cbits_s1;
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_v_q <= 1'b1;
			end else if (s2_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s2_adv) begin
				s2_v_q <= s1_v_q;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (accept) begin
			a0_s1 <= a0;
			a1_s1 <= a1;
			gt_s1 <= gt;
			asum_s1 <= asum;
			col0_s1 <= col0;
			col1_s1 <= col1;
			csum_s1 <= csum;
			abits_s1 <= lo[63:16];
			cbits_s1 <= hi[63:32];
		end
		if (s1_v_q && s2_adv) begin
			entry_s2 <= entry_nx;
		end
	end

endmodule

/* design/bc3d_queue.sv */
module bc3d_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input bc3d_pkg::entry_t wr_entry,
	input logic pop,
	output bc3d_pkg::entry_t rd_entry,
	output bc3d_pkg::qstat_t qstat
);

	bc3d_pkg::entry_t mem_q [bc3d_pkg::QDEPTH];
	logic [bc3d_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [bc3d_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [bc3d_pkg::QCNT_W-1:0] count_q;

	assign qstat.full = count_q == bc3d_pkg::QCNT_W'(bc3d_pkg::QDEPTH);
	assign qstat.empty = count_q == '0;
	assign rd_entry = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bc3d_pkg::QPTR_W'(bc3d_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bc3d_pkg::QPTR_W'(bc3d_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

/* design/bc3d_back.sv */
module bc3d_back (
	input logic clk,
	input logic arst_n,
	input bc3d_pkg::entry_t head,
	input bc3d_pkg::qstat_t qstat,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] row_index,
	output logic [63:0] left_pixels,
	output logic [63:0] right_pixels,
	output logic last_row
);

	logic [1:0] row_q;
	logic out_v_q;
	logic [1:0] row_idx_q;
	logic [63:0] left_q;
	logic [63:0] right_q;
	logic last_q;

	logic load;
	logic [11:0] arow;
	logic [7:0] crow;
	logic [3:0][31:0] texel;
	logic [2:0] ai;
	logic [1:0] ci;

	// A row is formed whenever a block waits and the output register is free.
	assign load = !qstat.empty && (!out_v_q || !out_stall);
	assign pop = load && (row_q == 2'd3);

	assign out_valid = out_v_q;
	assign row_index = row_idx_q;
	assign left_pixels = left_q;
	assign right_pixels = right_q;
	assign last_row = last_q;

	// Look up the four texels of the current row in the palettes.
	always_comb begin
		case (row_q)
			2'd0: arow = head.abits[11:0];
			2'd1: arow = head.abits[23:12];
			2'd2: arow = head.abits[35:24];
			default: arow = head.abits[47:36];
		endcase
		crow = head.cbits[{row_q, 3'b000} +: 8];
		for (int px = 0; px < 4; px++) begin
			ai = arow[3*px +: 3];
			ci = crow[2*px +: 2];
			texel[px] = {head.alpha[ai], head.color[ci]};
		end
	end

	// Row counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				row_q <= row_q + 1'b1;
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			row_idx_q <= row_q;
			left_q <= {texel[1], texel[0]};
			right_q <= {texel[3], texel[2]};
			last_q <= row_q == 2'd3;
		end
	end

endmodule

/* design/bc3_texture_block_decoder_unit.sv */
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    stored_low, stored_high
// out      output     out_valid/out_stall  row_index, left_pixels, right_pixels, last_row
//
// Each block gives four row transfers, one per cycle when out is not stalled.
// A block passes through both front stages and is then written into the queue;
// its first row is registered in the output register. The front takes blocks
// back to back until the two-entry queue and both front stages hold blocks.
// Reset is asynchronous and empties every stage.
module bc3_texture_block_decoder_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [63:0] stored_low,
	input logic [63:0] stored_high,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] row_index,
	output logic [63:0] left_pixels,
	output logic [63:0] right_pixels,
	output logic last_row
);

	logic push;
	logic pop;
	bc3d_pkg::entry_t wr_entry;
	bc3d_pkg::entry_t head;
	bc3d_pkg::qstat_t qstat;

	// Front: byte restore and palette build.
	bc3d_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stored_low(stored_low),
		.stored_high(stored_high),
		.qstat(qstat),
		.push(push),
		.entry(wr_entry)
	);

	// Queue of decoded blocks.
	bc3d_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_entry(wr_entry),
		.pop(pop),
		.rd_entry(head),
		.qstat(qstat)
	);

	// Back: per-row texel lookup and output register.
	bc3d_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.qstat(qstat),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.row_index(row_index),
		.left_pixels(left_pixels),
		.right_pixels(right_pixels),
		.last_row(last_row)
	);

endmodule

/* tb/tb_bc3_texture_block_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_bc3_texture_block_decoder_unit;

	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_BLOCKS = 180;
	localparam int SETTLE_CYCLES = 20;

	// One decoded texel row as the block presents it.
	typedef struct packed {
		logic [1:0] idx;
		logic [63:0] left;
		logic [63:0] right;
		logic last;
	} texel_row_t;

	// One directed block in stored form, with an optional fixed texel value.
	typedef struct packed {
		logic [127:0] blk;
		logic fixed;
		logic [63:0] fill;
	} directed_block_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [63:0] stored_low;
	logic [63:0] stored_high;
	logic out_valid;
	logic out_stall;
	logic [1:0] row_index;
	logic [63:0] left_pixels;
	logic [63:0] right_pixels;
	logic last_row;

	// Side information that travels with the block on the input channel.
	logic cur_fixed;
	logic [63:0] cur_fill;

	texel_row_t rows_pending[$];
	directed_block_t directed[$];
	bit quiet;
	int mismatches;
	int blocks_in;
	int rows_checked;
	int eight_level_blocks;
	int six_level_blocks;
	int equal_alpha_blocks;
	int low_first_color_blocks;
	int cycle_count;

	bc3_texture_block_decoder_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stored_low(stored_low),
		.stored_high(stored_high),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.row_index(row_index),
		.left_pixels(left_pixels),
		.right_pixels(right_pixels),
		.last_row(last_row)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Exchange the two bytes of every 16-bit pair; the operation is its own inverse.
	function automatic logic [63:0] swap_byte_pairs(input logic [63:0] x);
		return ((x & 64'h00FF00FF00FF00FF) << 8) | ((x >> 8) & 64'h00FF00FF00FF00FF);
	endfunction

	// Assemble a block from its logical fields and return it as stored, {high, low}.
	function automatic logic [127:0] pack_block(input logic [7:0] a0, input logic [7:0] a1,
			input logic [47:0] abits, input logic [15:0] c0, input logic [15:0] c1,
			input logic [31:0] cbits);
		return {swap_byte_pairs({cbits, c1, c0}), swap_byte_pairs({abits, a1, a0})};
	endfunction

	// Random byte that lands on the extremes fairly often.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Random 565 color that lands on black or white fairly often.
	function automatic logic [15:0] pick_color();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Append one row to the directed table.
	task automatic add_directed(input logic [127:0] blk, input logic fixed,
			input logic [63:0] fill);
		directed_block_t d;
		d.blk = blk;
		d.fixed = fixed;
		d.fill = fill;
		directed.insert(directed.size(), d);
	endtask

	// Decode one stored block into its four texel rows and queue them.
	task automatic queue_block_rows(input logic [63:0] s_lo, input logic [63:0] s_hi,
			input logic use_fill, input logic [63:0] fill);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [47:0] abits;
		logic [31:0] cbits;
		logic [15:0] ep;
		logic [31:0] texel;
		int a0;
		int a1;
		int alpha[8];
		int col[4][3];
		int ci;
		int ai;
		int t;
		texel_row_t r;
		lo = swap_byte_pairs(s_lo);
		hi = swap_byte_pairs(s_hi);
		a0 = lo[7:0];
		a1 = lo[15:8];
		abits = lo[63:16];
		cbits = hi[63:32];

		// Alpha palette: sevenths when the first endpoint is larger, else fifths plus 0 and 255.
		alpha[0] = a0;
		alpha[1] = a1;
		if (a0 > a1) begin
			eight_level_blocks++;
			for (int i = 1; i < 7; i++)
				alpha[i + 1] = ((7 - i) * a0 + i * a1) / 7;
		end else begin
			six_level_blocks++;
			if (a0 == a1)
				equal_alpha_blocks++;
			for (int i = 1; i < 5; i++)
				alpha[i + 1] = ((5 - i) * a0 + i * a1) / 5;
			alpha[6] = 0;
			alpha[7] = 255;
		end

		// Color endpoints widened by bit replication, then the two third points.
		if (hi[15:0] <= hi[31:16])
			low_first_color_blocks++;
		for (int e = 0; e < 2; e++) begin
			ep = hi[16 * e +: 16];
			col[e][0] = {ep[15:11], ep[15:13]};
			col[e][1] = {ep[10:5], ep[10:9]};
			col[e][2] = {ep[4:0], ep[4:2]};
		end
		for (int c = 0; c < 3; c++) begin
			col[2][c] = (2 * col[0][c] + col[1][c]) / 3;
			col[3][c] = (col[0][c] + 2 * col[1][c]) / 3;
		end

		// Rows are produced top to bottom, texel 0 in the low word.
		for (int row = 0; row < 4; row++) begin
			r.idx = 2'(row);
			r.last = (row == 3);
			r.left = '0;
			r.right = '0;
			for (int px = 0; px < 4; px++) begin
				t = row * 4 + px;
				ci = cbits[2 * t +: 2];
				ai = abits[3 * t +: 3];
				texel = {8'(alpha[ai]), 8'(col[ci][2]), 8'(col[ci][1]), 8'(col[ci][0])};
				if (px < 2)
					r.left[32 * px +: 32] = texel;
				else
					r.right[32 * (px - 2) +: 32] = texel;
			end
			if (use_fill) begin
				r.left = fill;
				r.right = fill;
			end
			rows_pending.insert(rows_pending.size(), r);
		end
	endtask

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Present one block, possibly after an idle burst, and hold it until the transfer.
	task automatic send_block(input logic [127:0] blk, input logic fixed,
			input logic [63:0] fill);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		stored_low <= blk[63:0];
		stored_high <= blk[127:64];
		cur_fixed <= fixed;
		cur_fill <= fill;
		do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
	endtask

	// Stop sending and wait until every queued row has been received.
	task automatic wait_rows_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (rows_pending.size() != 0) @(negedge clk);
	endtask

	// Both channels are observed at the rising edge.
	always @(posedge clk) begin : watch_channels
		texel_row_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				queue_block_rows(stored_low, stored_high, cur_fixed, cur_fill);
				blocks_in++;
			end
			if (out_valid && !out_stall) begin
				if (rows_pending.size() == 0) begin
					$display("%0t ns: unexpected row transfer, row %0d left %h right %h",
						$time, row_index, left_pixels, right_pixels);
					mismatches++;
				end else begin
					want = rows_pending.pop_front();
					check_field("row_index", 64'(want.idx), 64'(row_index));
					check_field("left_pixels", want.left, left_pixels);
					check_field("right_pixels", want.right, right_pixels);
					check_field("last_row", 64'(want.last), 64'(last_row));
					rows_checked++;
				end
			end
		end
	end

	// Receiver stalls in random bursts until the final quiet stretch.
	initial begin : row_receiver
		int burst;
		logic stall_next;
		burst = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (burst > 0) begin
				burst--;
				stall_next = 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 9) - 1;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			out_stall <= stall_next;
		end
	end

	// A hung handshake ends the run here.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d rows still expected", cycle_count,
			rows_pending.size());
		$display("bc3_texture_block_decoder_unit: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [127:0] blk;
		logic [7:0] a0;
		logic [7:0] a1;
		logic [15:0] c0;
		logic [15:0] c1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		stored_low = '0;
		stored_high = '0;
		cur_fixed = 1'b0;
		cur_fill = '0;
		quiet = 1'b0;
		mismatches = 0;
		blocks_in = 0;
		rows_checked = 0;
		eight_level_blocks = 0;
		six_level_blocks = 0;
		equal_alpha_blocks = 0;
		low_first_color_blocks = 0;

		// Directed blocks: all-zero and all-one blocks have an obvious uniform result.
		add_directed(128'h0, 1'b1, 64'h0);
		add_directed({128{1'b1}}, 1'b1, {64{1'b1}});
		// Every alpha and color index in turn, across both alpha branches.
		add_directed(pack_block(8'd255, 8'd0, {2{24'o76543210}}, 16'hFFFF, 16'h0000,
			32'hE4E4E4E4), 1'b0, 64'h0);
		add_directed(pack_block(8'd0, 8'd255, {2{24'o76543210}}, 16'h0000, 16'hFFFF,
			32'hE4E4E4E4), 1'b0, 64'h0);
		// Equal alpha endpoints fall into the six-level branch.
		add_directed(pack_block(8'd128, 8'd128, {2{24'o76543210}}, 16'hF800, 16'h07E0,
			32'hE4E4E4E4), 1'b0, 64'h0);
		add_directed(pack_block(8'd0, 8'd0, {2{24'o76543210}}, 16'h001F, 16'hF800,
			32'h1B1B1B1B), 1'b0, 64'h0);
		add_directed(pack_block(8'd255, 8'd255, {2{24'o01234567}}, 16'hFFFF, 16'hFFFF,
			32'h1B1B1B1B), 1'b0, 64'h0);
		// Endpoints one apart on each side of the branch point.
		add_directed(pack_block(8'd1, 8'd0, {2{24'o76543210}}, 16'h8410, 16'h8410,
			32'hE4E4E4E4), 1'b0, 64'h0);
		add_directed(pack_block(8'd0, 8'd1, {2{24'o76543210}}, 16'h07E0, 16'h001F,
			32'hE4E4E4E4), 1'b0, 64'h0);
		add_directed(pack_block(8'd255, 8'd254, {2{24'o76543210}}, 16'h0001, 16'h0000,
			32'hE4E4E4E4), 1'b0, 64'h0);
		add_directed(pack_block(8'd254, 8'd255, {2{24'o76543210}}, 16'h0000, 16'h0001,
			32'hE4E4E4E4), 1'b0, 64'h0);
		// The second color endpoint larger still uses the four-color palette.
		add_directed(pack_block(8'd200, 8'd50, {2{24'o70707070}}, 16'h1234, 16'hFEDC,
			32'hFFAA5500), 1'b0, 64'h0);
		// Alternating and single-bit raw patterns.
		add_directed({64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA}, 1'b0, 64'h0);
		add_directed({64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555}, 1'b0, 64'h0);
		add_directed({64'h0000000000000001, 64'h8000000000000001}, 1'b0, 64'h0);
		add_directed({64'h8000000000000000, 64'h0000000000000080}, 1'b0, 64'h0);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_block(directed[i].blk, directed[i].fixed, directed[i].fill);
		wait_rows_drained();

		// Random blocks: mostly built from chosen endpoints, the rest raw bits.
		for (int n = 0; n < RANDOM_BLOCKS; n++) begin
			if (n == RANDOM_BLOCKS / 2)
				wait_rows_drained();
			if (n == RANDOM_BLOCKS - 30)
				quiet = 1'b1;
			if ($urandom_range(0, 9) < 7) begin
				a0 = pick_byte();
				a1 = ($urandom_range(0, 3) == 0) ? a0 : pick_byte();
				c0 = pick_color();
				c1 = ($urandom_range(0, 7) == 0) ? c0 : pick_color();
				blk = pack_block(a0, a1, {16'($urandom), 32'($urandom)}, c0, c1, $urandom);
			end else begin
				blk = {$urandom, $urandom, $urandom, $urandom};
			end
			send_block(blk, 1'b0, 64'h0);
		end

		wait_rows_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Decoded %0d blocks into %0d checked rows: %0d eight-level alpha, %0d six-level",
			blocks_in, rows_checked, eight_level_blocks, six_level_blocks);
		$display("(%0d with equal alpha endpoints), %0d with the first color not above the second.",
			equal_alpha_blocks, low_first_color_blocks);
		if (mismatches == 0) begin
			$display("bc3_texture_block_decoder_unit: match");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("bc3_texture_block_decoder_unit: mismatch");
		end
		$finish;
	end

endmodule
